// ===== rtl/fltm_pkg.sv =====
// ============================================================================
// fltm_pkg
// Shared constants and types for the four-level page table manager.
// ============================================================================
package fltm_pkg;

    localparam int NUM_TABLES        = 16;
    localparam int ENTRIES_PER_TABLE = 512;

    localparam int LEVEL_BITS  = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W     = $clog2(NUM_TABLES);
    localparam int NEXT_W      = $clog2(NUM_TABLES + 1);
    localparam int STORE_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
    localparam int STORE_AW    = FRAME_W + LEVEL_BITS;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int PFN_W   = PA_W - 12;

    localparam logic [11:0] LINK_BITS = 12'h007;

    typedef enum logic [1:0] {
        OP_MAP     = 2'd0,
        OP_UNMAP   = 2'd1,
        OP_PROTECT = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ALIGN = 2'd1,
        ST_NOMAP = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RESP
    } state_t;

endpackage

// ===== rtl/fltm_if.sv =====
// ============================================================================
// fltm channel interfaces
// Request, response and configuration channels with valid/ready transfer.
// ============================================================================
interface fltm_req_if;
    import fltm_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [VA_W-1:0]     virt_addr;
    logic [PA_W-1:0]     phys_addr;
    logic [ENTRY_W-1:0]  pte_flags;

    modport source (output valid, operation, virt_addr, phys_addr, pte_flags,
                    input ready);
    modport sink   (input valid, operation, virt_addr, phys_addr, pte_flags,
                    output ready);
endinterface

interface fltm_rsp_if;
    import fltm_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [PA_W-1:0]   result_phys;
    logic              tlb_invalidate;

    modport source (output valid, status, result_phys, tlb_invalidate,
                    input ready);
    modport sink   (input valid, status, result_phys, tlb_invalidate,
                    output ready);
endinterface

interface fltm_cfg_if;
    import fltm_pkg::*;

    logic              valid;
    logic              ready;
    logic [PA_W-1:0]   table_base_phys;

    modport source (output valid, table_base_phys, input ready);
    modport sink   (input valid, table_base_phys, output ready);
endinterface

// ===== rtl/four_level_page_table_manager.sv =====
// ============================================================================
// four_level_page_table_manager
// Four-level radix page table held in one local table store.
// ============================================================================
// After reset the block sweeps the whole table store (NUM_TABLES*512 = 8192
// entries) to zero, one entry per cycle, and accepts no request until the
// sweep is done; configuration writes are taken at any time. A request is
// then accepted; each table level walked is a read of the single store port
// plus an evaluate step on the registered entry, which may write back a link
// or leaf; the result is posted once the output register is free. A walk that
// stops early skips its remaining levels; a misaligned request skips the walk.
// One request is in flight at a time; the output register holds a finished
// result while the next request is taken. Each store word carries an extra
// tag bit recording whether its frame was allocated when it was written, so a
// freshly allocated table reads as zero without a clearing sweep.
module four_level_page_table_manager (
    input  logic        clk,
    input  logic        rst_n,
    fltm_req_if.sink    req,
    fltm_rsp_if.source  rsp,
    fltm_cfg_if.sink    cfg
);
    import fltm_pkg::*;

    // table store: {alloc tag, entry}
    logic [ENTRY_W:0] store_mem [STORE_DEPTH];
    logic [ENTRY_W:0] mem_q;

    logic                mem_we;
    logic                mem_re;
    logic [STORE_AW-1:0] mem_waddr;
    logic [STORE_AW-1:0] mem_raddr;
    logic [ENTRY_W:0]    mem_wdata;

    state_t              state_reg, state_next;
    logic [1:0]          level_reg, level_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [NEXT_W-1:0]   next_free_reg, next_free_next;
    logic [PA_W-1:0]     base_reg, base_next;
    logic [STORE_AW-1:0] clr_reg, clr_next;
    op_t                 op_reg, op_next;
    logic [VA_W-1:0]     va_reg, va_next;
    logic [PA_W-1:0]     pa_reg, pa_next;
    logic [ENTRY_W-1:0]  flags_reg, flags_next;
    status_t             status_reg, status_next;
    logic [PA_W-1:0]     phys_reg, phys_next;
    logic                inv_reg, inv_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [PA_W-1:0]     out_phys_reg, out_phys_next;
    logic                out_inv_reg, out_inv_next;

    logic [LEVEL_BITS-1:0] lvl_idx;
    logic [ENTRY_W-1:0]    entry;
    logic                  frame_alloc;
    logic [PFN_W-1:0]      link_pfn;
    logic [PFN_W-1:0]      link_diff;
    logic                  link_ok;
    logic [PFN_W-1:0]      new_pfn;
    logic                  misaligned;
    logic                  out_free;

    // ------------------------------------------------------------------------
    // Table store
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q <= store_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Walk datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        case (level_reg)
            2'd0:    lvl_idx = va_reg[47:39];
            2'd1:    lvl_idx = va_reg[38:30];
            2'd2:    lvl_idx = va_reg[29:21];
            default: lvl_idx = va_reg[20:12];
        endcase
    end

    // an entry written before its frame was allocated reads as zero afterwards
    assign frame_alloc = {1'b0, frame_reg} < next_free_reg;
    assign entry       = (mem_q[ENTRY_W] || !frame_alloc) ? mem_q[ENTRY_W-1:0]
                                                          : '0;

    assign link_pfn  = entry[PA_W-1:12];
    assign link_diff = link_pfn - base_reg[PA_W-1:12];
    assign link_ok   = (link_pfn >= base_reg[PA_W-1:12]) &&
                       (link_diff < PFN_W'(NUM_TABLES));
    assign new_pfn   = base_reg[PA_W-1:12] + PFN_W'(next_free_reg);

    assign misaligned = ((op_t'(req.operation) == OP_MAP) &&
                         (req.phys_addr[11:0] != 12'd0)) ||
                        (req.virt_addr[11:0] != 12'd0);

    assign out_free = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        frame_next      = frame_reg;
        next_free_next  = next_free_reg;
        base_next       = base_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        va_next         = va_reg;
        pa_next         = pa_reg;
        flags_next      = flags_reg;
        status_next     = status_reg;
        phys_next       = phys_reg;
        inv_next        = inv_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_phys_next   = out_phys_reg;
        out_inv_next    = out_inv_reg;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = {frame_reg, lvl_idx};
        mem_raddr = {frame_reg, lvl_idx};
        mem_wdata = '0;
        req.ready = 1'b0;

        if (cfg.valid)
        begin
            base_next = cfg.table_base_phys;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + STORE_AW'(1);
                if (clr_reg == STORE_AW'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next     = op_t'(req.operation);
                    va_next     = req.virt_addr;
                    pa_next     = req.phys_addr;
                    flags_next  = req.pte_flags;
                    level_next  = 2'd0;
                    frame_next  = '0;
                    phys_next   = '0;
                    inv_next    = 1'b0;
                    status_next = ST_OK;
                    if (misaligned)
                    begin
                        status_next = ST_ALIGN;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (level_reg != 2'd3)
                begin
                    if (entry[0])
                    begin
                        if (link_ok)
                        begin
                            frame_next = link_diff[FRAME_W-1:0];
                            level_next = level_reg + 2'd1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            status_next = ST_NOMAP;
                            state_next  = S_RESP;
                        end
                    end
                    else if (op_reg != OP_MAP)
                    begin
                        status_next = ST_NOMAP;
                        state_next  = S_RESP;
                    end
                    else if (next_free_reg >= NEXT_W'(NUM_TABLES))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        // tag against the count after this allocation
                        mem_we         = 1'b1;
                        mem_wdata      = {({1'b0, frame_reg} <= next_free_reg),
                                          12'd0, new_pfn, LINK_BITS};
                        frame_next     = next_free_reg[FRAME_W-1:0];
                        next_free_next = next_free_reg + NEXT_W'(1);
                        level_next     = level_reg + 2'd1;
                        state_next     = S_READ;
                    end
                end
                else
                begin
                    state_next = S_RESP;
                    case (op_reg)
                        OP_MAP:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {frame_alloc,
                                         ({12'd0, pa_reg[PA_W-1:12], 12'd0} |
                                          flags_reg | ENTRY_W'(1))};
                            inv_next  = 1'b1;
                        end
                        OP_UNMAP:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {frame_alloc, {ENTRY_W{1'b0}}};
                            inv_next  = 1'b1;
                        end
                        OP_PROTECT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {frame_alloc,
                                         ({12'd0, entry[PA_W-1:12], 12'd0} |
                                          flags_reg | ENTRY_W'(1))};
                        end
                        default:
                        begin
                            phys_next = {entry[PA_W-1:12], 12'd0};
                        end
                    endcase
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_phys_next   = phys_reg;
                    out_inv_next    = inv_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= NEXT_W'(1);
            base_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            frame_reg     <= '0;
        end
        else
        begin
            next_free_reg <= next_free_next;
            base_reg      <= base_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
            frame_reg     <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        va_reg         <= va_next;
        pa_reg         <= pa_next;
        flags_reg      <= flags_next;
        status_reg     <= status_next;
        phys_reg       <= phys_next;
        inv_reg        <= inv_next;
        out_status_reg <= out_status_next;
        out_phys_reg   <= out_phys_next;
        out_inv_reg    <= out_inv_next;
    end

    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_phys    = out_phys_reg;
    assign rsp.tlb_invalidate = out_inv_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= NEXT_W'(NUM_TABLES))
        else $error("table allocation counter past store size");

    a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |->
            (next_free_reg == $past(next_free_reg) + NEXT_W'(1)))
        else $error("table allocation counter moved by more than one");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and write in the same cycle");

    a_inv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.tlb_invalidate || (rsp.result_phys != '0))) |->
            (rsp.status == ST_OK))
        else $error("invalidate or address returned with failing status");

endmodule
